// File: rtl/opl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opl_pkg
// shared sizes, opcode and status codes, result record and narrowing helpers
// for the ordered pointer list
// ----------------------------------------------------------------------------
package opl_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 64;

    localparam logic [2:0] OP_APPEND       = 3'd0;
    localparam logic [2:0] OP_FIND         = 3'd1;
    localparam logic [2:0] OP_READ         = 3'd2;
    localparam logic [2:0] OP_REMOVE_VALUE = 3'd3;
    localparam logic [2:0] OP_REMOVE_AT    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        found_index;
        logic [DATA_W-1:0] read_value;
        logic [4:0]        entry_count;
    } t_res;

    // index modulo 16
    function automatic logic [3:0] to_idx4(input logic [CW-1:0] c);
        logic [CW+3:0] t;
        t = {4'b0000, c};
        return t[3:0];
    endfunction

    // count modulo 32
    function automatic logic [4:0] to_cnt5(input logic [CW-1:0] c);
        logic [CW+4:0] t;
        t = {5'b00000, c};
        return t[4:0];
    endfunction

    // entry address from a count-wide index
    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] c);
        return c[AW-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/opl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module opl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/opl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opl_seq
// request sequencer: decodes one request, walks the entry ram for search and
// gap closing, keeps the entry count and builds the result record
// ----------------------------------------------------------------------------
module opl_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2:0]                 i_opcode,
    input  wire logic [opl_pkg::DATA_W-1:0] i_value,
    input  wire logic [3:0]                 i_position,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output opl_pkg::t_res                   o_res,
    output logic                            o_we,
    output logic [opl_pkg::AW-1:0]          o_waddr,
    output logic [opl_pkg::DATA_W-1:0]      o_wdata,
    output logic [opl_pkg::AW-1:0]          o_raddr,
    input  wire logic [opl_pkg::DATA_W-1:0] i_rdata
);

    localparam int CW = opl_pkg::CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_idx, n_idx;
    logic [1:0]                 r_status, n_status;
    logic [opl_pkg::DATA_W-1:0] r_rdval, n_rdval;
    logic [opl_pkg::DATA_W-1:0] r_val, n_val;
    logic [2:0]                 r_op, n_op;

    logic [CW-1:0] w_ptr_p1;
    logic [CW-1:0] w_ptr_p2;
    logic [CW+3:0] w_pos_ext;
    logic          w_pos_ok;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_pos_p1;
    logic          w_full;

    assign w_ptr_p1  = r_ptr + CW'(1);
    assign w_ptr_p2  = r_ptr + CW'(2);
    assign w_pos_ext = {{CW{1'b0}}, i_position};
    assign w_pos_ok  = w_pos_ext < {4'b0000, r_count};
    // only used when in range, so the low bits hold the whole position
    assign w_pos     = w_pos_ext[CW-1:0];
    assign w_pos_p1  = w_pos + CW'(1);
    assign w_full    = r_count == CW'(opl_pkg::CAPACITY);

    assign o_ready     = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res.status      = r_status;
    assign o_res.found_index = opl_pkg::to_idx4(r_idx);
    assign o_res.read_value  = r_rdval;
    assign o_res.entry_count = opl_pkg::to_cnt5(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_idx    = r_idx;
        n_status = r_status;
        n_rdval  = r_rdval;
        n_val    = r_val;
        n_op     = r_op;
        o_we     = 1'b0;
        o_waddr  = opl_pkg::to_addr(r_ptr);
        o_wdata  = i_rdata;
        o_raddr  = opl_pkg::to_addr(w_ptr_p1);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = i_value;
                    n_op     = i_opcode;
                    n_status = opl_pkg::ST_OK;
                    n_idx    = '0;
                    n_rdval  = '0;
                    n_state  = S_DONE;
                    unique case (i_opcode) inside
                        opl_pkg::OP_APPEND: begin
                            if (w_full) begin
                                n_status = opl_pkg::ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = opl_pkg::to_addr(r_count);
                                o_wdata = i_value;
                                n_idx   = r_count;
                                n_count = r_count + CW'(1);
                            end
                        end
                        opl_pkg::OP_FIND, opl_pkg::OP_REMOVE_VALUE: begin
                            if (r_count == '0) begin
                                n_status = opl_pkg::ST_MISSING;
                            end else begin
                                o_raddr = '0;
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        opl_pkg::OP_READ: begin
                            if (!w_pos_ok) begin
                                n_status = opl_pkg::ST_RANGE;
                            end else begin
                                o_raddr = opl_pkg::to_addr(w_pos);
                                n_state = S_RDWAIT;
                            end
                        end
                        opl_pkg::OP_REMOVE_AT: begin
                            if (!w_pos_ok) begin
                                n_status = opl_pkg::ST_RANGE;
                            end else if (w_pos_p1 == r_count) begin
                                // last entry: nothing to close up
                                n_count = r_count - CW'(1);
                            end else begin
                                o_raddr = opl_pkg::to_addr(w_pos_p1);
                                n_ptr   = w_pos;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read data belongs to r_ptr, next address already issued
                if (i_rdata == r_val) begin
                    n_idx = r_ptr;
                    if (r_op == opl_pkg::OP_FIND) begin
                        n_state = S_DONE;
                    end else if (w_ptr_p1 == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (w_ptr_p1 == r_count) begin
                    n_status = opl_pkg::ST_MISSING;
                    n_state  = S_DONE;
                end else begin
                    n_ptr = w_ptr_p1;
                end
            end
            S_RDWAIT: begin
                n_rdval = i_rdata;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                // entry r_ptr+1 arrives, write it one place down
                o_we    = 1'b1;
                o_waddr = opl_pkg::to_addr(r_ptr);
                o_wdata = i_rdata;
                o_raddr = opl_pkg::to_addr(w_ptr_p2);
                if (w_ptr_p2 == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_ptr = w_ptr_p1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rdval  <= n_rdval;
        r_val    <= n_val;
        r_op     <= n_op;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(opl_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CW'(1) || $past(r_count) == r_count + CW'(1)))
        else $error("entry count moved by more than one");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (w_ptr_p1 < r_count))
        else $error("gap closing outside the list");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr < r_count))
        else $error("search beyond last entry");

endmodule
`default_nettype wire

// File: rtl/ordered_pointer_list.sv
`timescale 1ns / 1ps
`default_nettype none
// append, rejected and unknown requests pass from the sequencer's done state to
// the output register; read waits on the ram, find scans from index 0 to a hit
// or the last entry; removes close the gap (count-1-index entries), one write each
// one request in flight; the next input transfer is taken the cycle after the
// result moves into the output register, even while that register is stalled
// reset clears the count and the handshake state; entry ram is not cleared
// ----------------------------------------------------------------------------
// ordered_pointer_list
// ordered list of 64-bit values with linear search, read, append and removal
// with gap closing, held in one synchronous ram
// ----------------------------------------------------------------------------
module ordered_pointer_list (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2:0]                 i_opcode,
    input  wire logic [opl_pkg::DATA_W-1:0] i_value,
    input  wire logic [3:0]                 i_position,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [1:0]                      o_status,
    output logic [3:0]                      o_found_index,
    output logic [opl_pkg::DATA_W-1:0]      o_read_value,
    output logic [4:0]                      o_entry_count
);

    // sequencer to output register
    opl_pkg::t_res w_res;
    logic          w_res_valid;
    logic          w_res_ready;

    // entry ram ports
    logic                       w_we;
    logic [opl_pkg::AW-1:0]     w_waddr;
    logic [opl_pkg::DATA_W-1:0] w_wdata;
    logic [opl_pkg::AW-1:0]     w_raddr;
    logic [opl_pkg::DATA_W-1:0] w_rdata;

    // output register, parts the sequencer from the result consumer
    logic          r_out_valid;
    opl_pkg::t_res r_out;

    opl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    opl_ram #(
        .WIDTH (opl_pkg::DATA_W),
        .DEPTH (opl_pkg::CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // room when empty or when the held result leaves this cycle
    assign w_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found_index;
    assign o_read_value  = r_out.read_value;
    assign o_entry_count = r_out.entry_count;

endmodule
`default_nettype wire
